>>> src/pjca_pkg.sv
// Shared types, codes and constants for the PNG/JPEG container admission block.
// Used by the byte walker, the top level and the port checker.
package pjca_pkg;

  // Default width of the image length counters
  localparam int LENGTH_BITS_DEF = 32;

  // Verdict codes
  localparam logic [1:0] V_OK      = 2'd0;
  localparam logic [1:0] V_INVALID = 2'd1;
  localparam logic [1:0] V_MULTI   = 2'd2;

  // PNG signature lead byte and chunk type tags
  localparam logic [7:0]  PNG_LEAD = 8'd137;
  localparam logic [31:0] TAG_ACTL = 32'h6163544c;
  localparam logic [31:0] TAG_IEND = 32'h49454e44;

  // JPEG marker bytes and the multi-picture tag
  localparam logic [7:0]  JPG_FF    = 8'hff;
  localparam logic [7:0]  JPG_SOI   = 8'hd8;
  localparam logic [7:0]  JPG_SOS   = 8'hda;
  localparam logic [7:0]  JPG_EOI   = 8'hd9;
  localparam logic [7:0]  JPG_TEM   = 8'h01;
  localparam logic [7:0]  JPG_RST0  = 8'hd0;
  localparam logic [7:0]  JPG_RST7  = 8'hd7;
  localparam logic [7:0]  JPG_APP2  = 8'he2;
  localparam logic [31:0] TAG_MPF   = 32'h4d504600;

  // Parse phases of the byte walk
  typedef enum logic [3:0] {
    PH_SIG        = 4'd0,
    PH_PNG_SIG    = 4'd1,
    PH_PNG_HEAD   = 4'd2,
    PH_PNG_BODY   = 4'd3,
    PH_JPG_SOI    = 4'd4,
    PH_JPG_FF     = 4'd5,
    PH_JPG_FILL   = 4'd6,
    PH_JPG_LEN_HI = 4'd7,
    PH_JPG_LEN_LO = 4'd8,
    PH_JPG_BODY   = 4'd9
  } phase_t;

  // Walk state that does not depend on the length width
  typedef struct packed {
    phase_t      phase;
    logic [2:0]  sub_idx;     // signature / chunk header / segment body byte index
    logic [7:0]  marker;      // current JPEG marker code
    logic        given;       // verdict for this image is out
    logic [31:0] field_shift; // collects multi-byte fields
    logic [31:0] seg_len;     // PNG chunk length or JPEG segment length
  } walk_state_t;

  localparam walk_state_t WALK_IDLE = '{
    phase:       PH_SIG,
    sub_idx:     3'd0,
    marker:      8'd0,
    given:       1'b0,
    field_shift: 32'd0,
    seg_len:     32'd0
  };

  // Byte i of the 8-byte PNG signature
  function automatic logic [7:0] png_sig_byte(input logic [2:0] i);
    logic [7:0] r;
    unique case (i)
      3'd0: r = 8'd137;
      3'd1: r = 8'd80;
      3'd2: r = 8'd78;
      3'd3: r = 8'd71;
      3'd4: r = 8'd13;
      3'd5: r = 8'd10;
      3'd6: r = 8'd26;
      3'd7: r = 8'd10;
      default: r = 8'd0;
    endcase
    return r;
  endfunction

endpackage

>>> src/pjca_walker.sv
// Next-state and verdict logic for one byte of the PNG chunk / JPEG marker walk.
// Depends on pjca_pkg; purely combinational, registered by the top level.
module pjca_walker #(
  parameter int LENGTH_BITS = pjca_pkg::LENGTH_BITS_DEF
) (
  input  pjca_pkg::walk_state_t    st_cur,
  input  logic [LENGTH_BITS-1:0]   left_cur,   // bytes left in the image, this one included
  input  logic [LENGTH_BITS-1:0]   skip_cur,
  input  logic [7:0]               data_byte,
  output pjca_pkg::walk_state_t    st_nxt,
  output logic [LENGTH_BITS-1:0]   left_nxt,
  output logic [LENGTH_BITS-1:0]   skip_nxt,
  output logic                     verdict_valid,
  output logic [1:0]               verdict
);
  import pjca_pkg::*;

  logic [31:0]            fs;
  logic [32:0]            chunk_end;
  logic [32:0]            left_wide;
  logic [15:0]            jpg_len;
  logic [LENGTH_BITS:0]   jpg_lim;
  logic                   png_short;
  logic                   jpg_short;

  // Shift the byte into the field collector
  assign fs        = {st_cur.field_shift[23:0], data_byte};
  // Chunk end relative to this byte: length + CRC(4) + this byte
  assign chunk_end = {1'b0, st_cur.seg_len} + 33'd5;
  assign left_wide = 33'(left_cur);
  assign jpg_len   = {st_cur.field_shift[7:0], data_byte};
  assign jpg_lim   = {1'b0, left_cur} + (LENGTH_BITS+1)'(1);
  // Next PNG chunk header and CRC (12 bytes) do not fit after this byte
  assign png_short = left_cur < LENGTH_BITS'(13);
  // No byte left after this one for the next JPEG marker
  assign jpg_short = left_cur <= LENGTH_BITS'(1);

  always_comb begin
    st_nxt        = st_cur;
    left_nxt      = left_cur - LENGTH_BITS'(1);
    skip_nxt      = skip_cur;
    verdict_valid = 1'b0;
    verdict       = V_OK;

    if (st_cur.given) begin
      // Consume silently until the next image starts
      left_nxt = left_cur;
    end else begin
      unique case (st_cur.phase)
        PH_SIG: begin
          if (data_byte == PNG_LEAD && left_cur >= LENGTH_BITS'(8)) begin
            st_nxt.phase   = PH_PNG_SIG;
            st_nxt.sub_idx = 3'd1;
          end else if (data_byte == JPG_FF && left_cur >= LENGTH_BITS'(2)) begin
            st_nxt.phase = PH_JPG_SOI;
          end else begin
            verdict_valid = 1'b1;
            verdict       = V_OK;
          end
        end
        PH_PNG_SIG: begin
          if (data_byte != png_sig_byte(st_cur.sub_idx)) begin
            verdict_valid = 1'b1;
            verdict       = V_OK;
          end else if (st_cur.sub_idx == 3'd7) begin
            if (png_short) begin
              verdict_valid = 1'b1;
              verdict       = V_INVALID;
            end else begin
              st_nxt.phase       = PH_PNG_HEAD;
              st_nxt.sub_idx     = 3'd0;
              st_nxt.field_shift = 32'd0;
            end
          end else begin
            st_nxt.sub_idx = st_cur.sub_idx + 3'd1;
          end
        end
        PH_PNG_HEAD: begin
          // Collect length then type, decide on the last type byte
          st_nxt.field_shift = fs;
          st_nxt.sub_idx     = st_cur.sub_idx + 3'd1;
          if (st_cur.sub_idx == 3'd3) begin
            st_nxt.seg_len = fs;
          end
          if (st_cur.sub_idx == 3'd7) begin
            if (chunk_end > left_wide) begin
              verdict_valid = 1'b1;
              verdict       = V_INVALID;
            end else if (fs == TAG_ACTL) begin
              verdict_valid = 1'b1;
              verdict       = V_MULTI;
            end else if (fs == TAG_IEND) begin
              verdict_valid = 1'b1;
              verdict = (st_cur.seg_len == 32'd0 && chunk_end == left_wide) ? V_OK : V_INVALID;
            end else begin
              skip_nxt     = LENGTH_BITS'(st_cur.seg_len) + LENGTH_BITS'(4);
              st_nxt.phase = PH_PNG_BODY;
            end
          end
        end
        PH_PNG_BODY: begin
          // Skip chunk data and CRC
          if (skip_cur != '0) begin
            skip_nxt = skip_cur - LENGTH_BITS'(1);
          end
          if (skip_cur <= LENGTH_BITS'(1)) begin
            if (png_short) begin
              verdict_valid = 1'b1;
              verdict       = V_INVALID;
            end else begin
              st_nxt.phase       = PH_PNG_HEAD;
              st_nxt.sub_idx     = 3'd0;
              st_nxt.field_shift = 32'd0;
            end
          end
        end
        PH_JPG_SOI: begin
          if (data_byte != JPG_SOI) begin
            verdict_valid = 1'b1;
            verdict       = V_OK;
          end else if (jpg_short) begin
            verdict_valid = 1'b1;
            verdict       = V_INVALID;
          end else begin
            st_nxt.phase = PH_JPG_FF;
          end
        end
        PH_JPG_FF: begin
          if (data_byte != JPG_FF || jpg_short) begin
            verdict_valid = 1'b1;
            verdict       = V_INVALID;
          end else begin
            st_nxt.phase = PH_JPG_FILL;
          end
        end
        PH_JPG_FILL: begin
          if (data_byte == JPG_FF) begin
            // Fill byte: stay unless the image runs out
            if (jpg_short) begin
              verdict_valid = 1'b1;
              verdict       = V_INVALID;
            end
          end else begin
            st_nxt.marker = data_byte;
            if (data_byte == JPG_SOS || data_byte == JPG_EOI) begin
              verdict_valid = 1'b1;
              verdict       = V_OK;
            end else if (data_byte == JPG_TEM ||
                         (data_byte >= JPG_RST0 && data_byte <= JPG_RST7)) begin
              // Standalone marker: look for the next one
              if (jpg_short) begin
                verdict_valid = 1'b1;
                verdict       = V_INVALID;
              end else begin
                st_nxt.phase = PH_JPG_FF;
              end
            end else if (data_byte == 8'd0 || left_cur < LENGTH_BITS'(3)) begin
              verdict_valid = 1'b1;
              verdict       = V_INVALID;
            end else begin
              st_nxt.phase = PH_JPG_LEN_HI;
            end
          end
        end
        PH_JPG_LEN_HI: begin
          st_nxt.field_shift = {24'd0, data_byte};
          st_nxt.phase       = PH_JPG_LEN_LO;
        end
        PH_JPG_LEN_LO: begin
          st_nxt.seg_len = {16'd0, jpg_len};
          if (jpg_len < 16'd2 || (LENGTH_BITS+1)'(jpg_len) > jpg_lim) begin
            verdict_valid = 1'b1;
            verdict       = V_INVALID;
          end else begin
            skip_nxt           = LENGTH_BITS'(jpg_len - 16'd2);
            st_nxt.field_shift = 32'd0;
            st_nxt.sub_idx     = 3'd0;
            if (jpg_len == 16'd2) begin
              if (jpg_short) begin
                verdict_valid = 1'b1;
                verdict       = V_INVALID;
              end else begin
                st_nxt.phase = PH_JPG_FF;
              end
            end else begin
              st_nxt.phase = PH_JPG_BODY;
            end
          end
        end
        PH_JPG_BODY: begin
          // Count the first four body bytes, check APP2 for the MPF tag
          if (!st_cur.sub_idx[2]) begin
            st_nxt.sub_idx = st_cur.sub_idx + 3'd1;
          end
          if (st_cur.marker == JPG_APP2 && st_cur.seg_len >= 32'd6 && !st_cur.sub_idx[2]) begin
            st_nxt.field_shift = fs;
          end
          if (st_cur.marker == JPG_APP2 && st_cur.seg_len >= 32'd6 &&
              st_cur.sub_idx == 3'd3 && fs == TAG_MPF) begin
            verdict_valid = 1'b1;
            verdict       = V_MULTI;
          end else begin
            if (skip_cur != '0) begin
              skip_nxt = skip_cur - LENGTH_BITS'(1);
            end
            if (skip_cur <= LENGTH_BITS'(1)) begin
              if (jpg_short) begin
                verdict_valid = 1'b1;
                verdict       = V_INVALID;
              end else begin
                st_nxt.phase = PH_JPG_FF;
              end
            end
          end
        end
        default: begin
          verdict_valid = 1'b1;
          verdict       = V_INVALID;
        end
      endcase
      if (verdict_valid) begin
        st_nxt.given = 1'b1;
      end
    end
  end

endmodule

>>> src/png_jpeg_container_admission.sv
// A byte is taken into the input register, its verdict into the result register.
// Throughput: one byte per cycle unless stalled; the per-byte walk step sits between them.
// The input side stalls while a verdict waits in the output register to be taken.
// Reset (rst_n low, synchronous) clears the walk state, the length counters and both valids;
// no clearing pass. Top level: input register, walk state registers, verdict register.
module png_jpeg_container_admission #(
  parameter int LENGTH_BITS = pjca_pkg::LENGTH_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic [31:0] in_byte_count,
  input  logic        in_start_of_image,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_verdict
);
  import pjca_pkg::*;

  logic                   s1_valid_r;
  logic [7:0]             s1_byte_r;
  logic [LENGTH_BITS-1:0] s1_count_r;
  logic                   s1_start_r;
  logic                   s1_go;
  logic                   s1_fire;

  walk_state_t            st_r;
  walk_state_t            st_cur;
  walk_state_t            st_nxt;
  logic [LENGTH_BITS-1:0] left_r;
  logic [LENGTH_BITS-1:0] left_cur;
  logic [LENGTH_BITS-1:0] left_nxt;
  logic [LENGTH_BITS-1:0] skip_r;
  logic [LENGTH_BITS-1:0] skip_cur;
  logic [LENGTH_BITS-1:0] skip_nxt;
  logic                   vd_valid;
  logic [1:0]             vd_code;

  logic                   out_valid_r;
  logic [1:0]             out_verdict_r;

  // Advance the input word unless a verdict is held back by the sink
  assign s1_go    = !(out_valid_r && out_stall);
  assign s1_fire  = s1_valid_r && s1_go;
  assign in_stall = s1_valid_r && !s1_go;

  // Capture the input word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_byte_r  <= in_data_byte;
      s1_count_r <= in_byte_count[LENGTH_BITS-1:0];
      s1_start_r <= in_start_of_image;
    end
  end

  // Start of image drops the old walk and samples the total length
  always_comb begin
    if (s1_start_r) begin
      st_cur   = WALK_IDLE;
      left_cur = s1_count_r;
      skip_cur = '0;
    end else begin
      st_cur   = st_r;
      left_cur = left_r;
      skip_cur = skip_r;
    end
  end

  pjca_walker #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_walker (
    .st_cur        (st_cur),
    .left_cur      (left_cur),
    .skip_cur      (skip_cur),
    .data_byte     (s1_byte_r),
    .st_nxt        (st_nxt),
    .left_nxt      (left_nxt),
    .skip_nxt      (skip_nxt),
    .verdict_valid (vd_valid),
    .verdict       (vd_code)
  );

  // Update the walk state once per consumed word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= WALK_IDLE;
      left_r <= '0;
      skip_r <= '0;
    end else if (s1_fire) begin
      st_r   <= st_nxt;
      left_r <= left_nxt;
      skip_r <= skip_nxt;
    end
  end

  // Hold the verdict until the sink takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire && vd_valid) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && vd_valid) begin
      out_verdict_r <= vd_code;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_verdict = out_verdict_r;

endmodule

>>> src/pjca_checker.sv
// Port-level checker for png_jpeg_container_admission, attached by bind.
// Depends on pjca_pkg for the verdict codes and the signature lead bytes.
module pjca_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic [7:0]  in_data_byte,
  input logic        in_start_of_image,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  out_verdict
);
  import pjca_pkg::*;

  // Hold a stalled verdict
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_verdict))
    else $error("stalled verdict changed or dropped");

  // Never show an undefined verdict code
  a_out_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_verdict == V_OK || out_verdict == V_INVALID || out_verdict == V_MULTI))
    else $error("undefined verdict code");

  // Drop any verdict after reset
  a_reset: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("verdict present right after reset");

  // Admit an image that opens with neither signature, its verdict passing the input and result registers
  a_other_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_start_of_image &&
     in_data_byte != PNG_LEAD && in_data_byte != JPG_FF)
    ##1 !(out_valid && out_stall) |=> out_valid && out_verdict == V_OK)
    else $error("unknown format not admitted on its first byte");

endmodule

bind png_jpeg_container_admission pjca_checker u_pjca_checker (.*);

>>> test/testbench.sv
// Self-checking testbench for png_jpeg_container_admission: byte streams of PNG, JPEG and
// other images go in, and each verdict is compared with a typed-in expectation or an in-line model of the chunk walk.
// Depends on pjca_pkg (verdict codes, marker bytes, chunk tags, parse phases) and the RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import pjca_pkg::*;

  localparam int PENDING       = -1;
  localparam int R_OK          = int'(V_OK);
  localparam int R_INVALID     = int'(V_INVALID);
  localparam int R_MULTI       = int'(V_MULTI);
  localparam int RANDOM_BYTES  = 1325;
  localparam int HOLD_CYCLES   = 300;
  localparam int DRAIN_CYCLES  = 8;
  localparam int CYCLE_LIMIT   = 150000;
  localparam int PRINT_LIMIT   = 40;
  localparam bit CHECK_TYPED   = 1'b1;
  localparam bit CHECK_MODEL   = 1'b0;

  localparam logic [7:0] PNG_SIGNATURE [8] = '{8'd137, 8'd80, 8'd78, 8'd71,
                                               8'd13, 8'd10, 8'd26, 8'd10};

  // One directed word, with a verdict typed in where it is obvious
  typedef struct packed {
    logic [7:0]  data;
    logic [31:0] total;
    logic        sof;
    logic        typed;
    logic [1:0]  verdict;
  } row_t;

  localparam int N_DIRECTED = 29;
  localparam row_t DIRECTED [N_DIRECTED] = '{
    // bytes before any start belong to an empty image
    '{8'h00,    32'd0,         1'b0, CHECK_TYPED, V_OK},
    '{JPG_FF,   32'hffff_ffff, 1'b0, CHECK_MODEL, V_OK},
    // zero and short totals
    '{JPG_FF,   32'd0,         1'b1, CHECK_TYPED, V_OK},
    '{PNG_LEAD, 32'd7,         1'b1, CHECK_TYPED, V_OK},
    '{JPG_FF,   32'd1,         1'b1, CHECK_TYPED, V_OK},
    // unfinished PNG dropped by an early start, then nothing fits after SOI
    '{PNG_LEAD, 32'hffff_ffff, 1'b1, CHECK_MODEL, V_OK},
    '{8'd80,    32'h5a5a_a5a5, 1'b0, CHECK_MODEL, V_OK},
    '{JPG_FF,   32'd2,         1'b1, CHECK_MODEL, V_OK},
    '{JPG_SOI,  32'd0,         1'b0, CHECK_TYPED, V_INVALID},
    // JPEG with fill and standalone markers at the largest total
    '{JPG_FF,   32'hffff_ffff, 1'b1, CHECK_MODEL, V_OK},
    '{JPG_SOI,  32'd0,         1'b0, CHECK_MODEL, V_OK},
    '{JPG_FF,   32'd0,         1'b0, CHECK_MODEL, V_OK},
    '{JPG_FF,   32'd0,         1'b0, CHECK_MODEL, V_OK},
    '{JPG_RST0, 32'd0,         1'b0, CHECK_MODEL, V_OK},
    '{JPG_FF,   32'd0,         1'b0, CHECK_MODEL, V_OK},
    '{JPG_TEM,  32'd0,         1'b0, CHECK_MODEL, V_OK},
    '{JPG_FF,   32'd0,         1'b0, CHECK_MODEL, V_OK},
    '{JPG_RST7, 32'd0,         1'b0, CHECK_MODEL, V_OK},
    '{JPG_FF,   32'd0,         1'b0, CHECK_MODEL, V_OK},
    '{JPG_EOI,  32'd0,         1'b0, CHECK_TYPED, V_OK},
    // marker walk runs into the total
    '{JPG_FF,   32'd3,         1'b1, CHECK_MODEL, V_OK},
    '{JPG_SOI,  32'd0,         1'b0, CHECK_MODEL, V_OK},
    '{JPG_FF,   32'd0,         1'b0, CHECK_TYPED, V_INVALID},
    // zero marker code
    '{JPG_FF,   32'd10,        1'b1, CHECK_MODEL, V_OK},
    '{JPG_SOI,  32'd0,         1'b0, CHECK_MODEL, V_OK},
    '{JPG_FF,   32'd0,         1'b0, CHECK_MODEL, V_OK},
    '{8'h00,    32'd0,         1'b0, CHECK_TYPED, V_INVALID},
    // other format, then a byte after the verdict
    '{8'h00,    32'd1,         1'b1, CHECK_TYPED, V_OK},
    '{8'h55,    32'd0,         1'b0, CHECK_MODEL, V_OK}
  };

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_data_byte;
  logic [31:0] in_byte_count;
  logic        in_start_of_image;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_verdict;

  // Typed expectation travels with the word it belongs to
  bit          in_typed;
  logic [1:0]  in_typed_verdict;

  bit          calm = 1'b0;
  bit          hold_req = 1'b0;
  int          mismatches = 0;
  int          walked_bytes = 0;
  int          cycles = 0;
  logic [1:0]  verdict_q [$];
  logic [7:0]  img [$];

  // Walk state of the model
  phase_t      walk_phase = PH_SIG;
  logic [31:0] pos_q = '0;
  logic [31:0] total_q = '0;
  logic [31:0] shift_q = '0;
  logic [31:0] seglen_q = '0;
  logic [32:0] skip_q = '0;
  logic [7:0]  mark_q = '0;
  bit          given_q = 1'b0;

  png_jpeg_container_admission i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_data_byte      (in_data_byte),
    .in_byte_count     (in_byte_count),
    .in_start_of_image (in_start_of_image),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_verdict       (out_verdict)
  );

  always #5 clk = ~clk;

  task automatic report_mismatch(input string msg);
    if (mismatches < PRINT_LIMIT) begin
      $display("%0t ns: mismatch: %s", $time, msg);
    end
    mismatches++;
  endtask

  // Open the next PNG chunk at offset nxt, if a whole header and CRC still fit
  function automatic int png_chunk_at(input logic [63:0] nxt);
    logic [63:0] tot;
    tot = 64'(total_q);
    if (nxt >= tot || tot - nxt < 64'd12) return R_INVALID;
    walk_phase = PH_PNG_HEAD;
    mark_q = '0;
    shift_q = '0;
    return PENDING;
  endfunction

  // Expect the next JPEG marker at offset nxt
  function automatic int jpg_marker_at(input logic [63:0] nxt);
    if (nxt >= 64'(total_q)) return R_INVALID;
    walk_phase = PH_JPG_FF;
    return PENDING;
  endfunction

  // Advance the walk by one byte; PENDING while the image is not settled
  function automatic int walk_byte(input logic [7:0] b);
    logic [63:0] pos;
    logic [63:0] tot;
    logic [63:0] stop;
    logic [63:0] k;
    logic [2:0]  idx;
    pos = 64'(pos_q);
    tot = 64'(total_q);
    case (walk_phase)
      PH_SIG: begin
        if (b == PNG_LEAD && tot >= 64'd8) begin
          walk_phase = PH_PNG_SIG;
          return PENDING;
        end
        if (b == JPG_FF && tot >= 64'd2) begin
          walk_phase = PH_JPG_SOI;
          return PENDING;
        end
        return R_OK;
      end
      PH_PNG_SIG: begin
        if (b != PNG_SIGNATURE[pos[2:0]]) return R_OK;
        if (pos >= 64'd7) return png_chunk_at(64'd8);
        return PENDING;
      end
      PH_PNG_HEAD: begin
        shift_q = {shift_q[23:0], b};
        idx = mark_q[2:0];
        mark_q = 8'(idx) + 8'd1;
        if (idx == 3'd3) seglen_q = shift_q;
        if (idx < 3'd7) return PENDING;
        stop = pos + 64'd5 + 64'(seglen_q);
        if (stop > tot) return R_INVALID;
        if (shift_q == TAG_ACTL) return R_MULTI;
        if (shift_q == TAG_IEND) return (seglen_q == 0 && stop == tot) ? R_OK : R_INVALID;
        skip_q = 33'(seglen_q) + 33'd4;
        walk_phase = PH_PNG_BODY;
        return PENDING;
      end
      PH_PNG_BODY: begin
        if (skip_q != 0) skip_q = skip_q - 33'd1;
        if (skip_q == 0) return png_chunk_at(pos + 64'd1);
        return PENDING;
      end
      PH_JPG_SOI: begin
        if (b != JPG_SOI) return R_OK;
        return jpg_marker_at(64'd2);
      end
      PH_JPG_FF: begin
        if (b != JPG_FF || pos + 64'd1 >= tot) return R_INVALID;
        walk_phase = PH_JPG_FILL;
        return PENDING;
      end
      PH_JPG_FILL: begin
        if (b == JPG_FF) return (pos + 64'd1 >= tot) ? R_INVALID : PENDING;
        mark_q = b;
        if (b == JPG_SOS || b == JPG_EOI) return R_OK;
        if (b == JPG_TEM || (b >= JPG_RST0 && b <= JPG_RST7)) return jpg_marker_at(pos + 64'd1);
        if (b == 8'h00 || tot - (pos + 64'd1) < 64'd2) return R_INVALID;
        walk_phase = PH_JPG_LEN_HI;
        return PENDING;
      end
      PH_JPG_LEN_HI: begin
        shift_q = 32'(b);
        walk_phase = PH_JPG_LEN_LO;
        return PENDING;
      end
      PH_JPG_LEN_LO: begin
        seglen_q = {16'd0, shift_q[7:0], b};
        if (seglen_q < 32'd2 || (pos - 64'd1) + 64'(seglen_q) > tot) return R_INVALID;
        skip_q = 33'(seglen_q) - 33'd2;
        shift_q = '0;
        if (skip_q == 0) return jpg_marker_at(pos + 64'd1);
        walk_phase = PH_JPG_BODY;
        return PENDING;
      end
      PH_JPG_BODY: begin
        k = (64'(seglen_q) - 64'd2) - 64'(skip_q);
        if (mark_q == JPG_APP2 && seglen_q >= 32'd6 && k[31:0] < 32'd4) begin
          shift_q = {shift_q[23:0], b};
          if (k[31:0] == 32'd3 && shift_q == TAG_MPF) return R_MULTI;
        end
        if (skip_q != 0) skip_q = skip_q - 33'd1;
        if (skip_q == 0) return jpg_marker_at(pos + 64'd1);
        return PENDING;
      end
      default: return R_INVALID;
    endcase
  endfunction

  // One accepted word: restart on a start flag, then walk unless already settled
  function automatic int admit_step(input logic [7:0] b, input logic [31:0] cnt, input bit sof);
    int v;
    if (sof) begin
      walk_phase = PH_SIG;
      pos_q = '0;
      shift_q = '0;
      seglen_q = '0;
      skip_q = '0;
      mark_q = '0;
      given_q = 1'b0;
      total_q = cnt;
    end
    if (given_q) return PENDING;
    v = walk_byte(b);
    pos_q = pos_q + 32'd1;
    if (v == PENDING) return PENDING;
    given_q = 1'b1;
    return v;
  endfunction

  // Predict on every accepted input word
  always @(posedge clk) begin : admit_monitor
    int v;
    if (rst_n && in_valid && !in_stall) begin
      walked_bytes++;
      v = admit_step(in_data_byte, in_byte_count, in_start_of_image);
      if (in_typed) begin
        verdict_q.push_back(in_typed_verdict);
      end else if (v != PENDING) begin
        verdict_q.push_back(v[1:0]);
      end
    end
  end

  // Compare every accepted verdict with the oldest expectation
  always @(posedge clk) begin : verdict_check
    logic [1:0] want;
    if (rst_n && out_valid && !out_stall) begin
      if (verdict_q.size() == 0) begin
        report_mismatch($sformatf("verdict %0d with none expected", out_verdict));
      end else begin
        want = verdict_q.pop_front();
        if (out_verdict !== want) begin
          report_mismatch($sformatf("verdict %0d, expected %0d", out_verdict, want));
        end
      end
    end
  end

  // Receiver: random stalls, none in the calm stretch, solid during the hold-off
  always @(negedge clk) begin
    out_stall <= hold_req || (!calm && $urandom_range(0, 99) < 12);
  end

  // Hold off the receiver once for a long stretch so the block backs up
  initial begin
    wait (walked_bytes >= 400);
    @(posedge clk);
    hold_req = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_req = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  // Offer one word, idling first at random, and hold it until taken
  task automatic send_word(input logic [7:0] b, input logic [31:0] cnt, input bit sof,
                           input bit typed, input logic [1:0] tv);
    if (!calm && $urandom_range(0, 99) < 12) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid          <= 1'b1;
    in_data_byte      <= b;
    in_byte_count     <= cnt;
    in_start_of_image <= sof;
    in_typed          <= typed;
    in_typed_verdict  <= tv;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic void put_word(input logic [31:0] w);
    img.push_back(w[31:24]);
    img.push_back(w[23:16]);
    img.push_back(w[15:8]);
    img.push_back(w[7:0]);
  endfunction

  // Signature, a few ordinary chunks, then a closing chunk of some kind
  function automatic void make_png();
    int len;
    img = {};
    foreach (PNG_SIGNATURE[i]) img.push_back(PNG_SIGNATURE[i]);
    repeat ($urandom_range(0, 3)) begin
      len = $urandom_range(0, 12);
      put_word(32'(len));
      put_word($urandom());
      repeat (len) img.push_back(8'($urandom()));
      put_word($urandom());
    end
    case ($urandom_range(0, 7))
      0: begin
        put_word(32'd8);
        put_word(TAG_ACTL);
        repeat (8) img.push_back(8'($urandom()));
        put_word($urandom());
      end
      1: begin
        len = $urandom_range(1, 4);
        put_word(32'(len));
        put_word(TAG_IEND);
        repeat (len) img.push_back(8'($urandom()));
        put_word($urandom());
      end
      2: begin
        put_word($urandom() | 32'h8000_0000);
        put_word($urandom());
        repeat ($urandom_range(0, 4)) img.push_back(8'($urandom()));
      end
      default: begin
        put_word(32'd0);
        put_word(TAG_IEND);
        put_word($urandom());
      end
    endcase
  endfunction

  // SOI, segments with fill and standalone markers, then an ending of some kind
  function automatic void make_jpeg();
    int len;
    bit mpf;
    logic [7:0] code;
    img = {};
    img.push_back(JPG_FF);
    img.push_back(JPG_SOI);
    repeat ($urandom_range(0, 4)) begin
      img.push_back(JPG_FF);
      repeat ($urandom_range(0, 2)) img.push_back(JPG_FF);
      if ($urandom_range(0, 3) == 0) begin
        code = ($urandom_range(0, 1) == 0) ? JPG_TEM : JPG_RST0 + 8'($urandom_range(0, 7));
        img.push_back(code);
      end else begin
        mpf = ($urandom_range(0, 4) == 0);
        code = mpf ? JPG_APP2 : 8'($urandom_range(2, 254));
        if ((code >= JPG_RST0 && code <= JPG_RST7) || code == JPG_EOI || code == JPG_SOS) begin
          code = JPG_APP2 - 8'd1;
        end
        len = $urandom_range(2, 14);
        img.push_back(code);
        img.push_back(8'(len >> 8));
        img.push_back(8'(len));
        for (int i = 0; i < len - 2; i++) begin
          img.push_back((mpf && i < 4) ? 8'(TAG_MPF >> (24 - 8 * i)) : 8'($urandom()));
        end
      end
    end
    case ($urandom_range(0, 7))
      0: begin
        img.push_back(JPG_FF);
        img.push_back(JPG_EOI);
      end
      1: begin
        img.push_back(JPG_FF);
        img.push_back(8'h00);
      end
      2: begin
        img.push_back(JPG_FF);
        img.push_back(JPG_APP2 - 8'd1);
        img.push_back(8'($urandom()));
        img.push_back(8'($urandom()));
      end
      3: begin
        img.push_back(JPG_FF);
        img.push_back(JPG_APP2 - 8'd1);
        img.push_back(8'h00);
        img.push_back(8'($urandom_range(0, 1)));
      end
      4: ;
      default: begin
        img.push_back(JPG_FF);
        img.push_back(JPG_SOS);
        repeat ($urandom_range(0, 6)) img.push_back(8'($urandom()));
      end
    endcase
  endfunction

  initial begin : stimulus
    logic [31:0] total;
    int n;
    int pick;
    int cut;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data_byte = '0;
    in_byte_count = '0;
    in_start_of_image = 1'b0;
    in_typed = 1'b0;
    in_typed_verdict = V_OK;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    // Directed words
    foreach (DIRECTED[i]) begin
      send_word(DIRECTED[i].data, DIRECTED[i].total, DIRECTED[i].sof,
                DIRECTED[i].typed, DIRECTED[i].verdict);
    end

    // Random images, mostly well formed, with broken totals, flipped bits and early starts
    while (walked_bytes < N_DIRECTED + RANDOM_BYTES) begin
      calm = (walked_bytes >= 800 && walked_bytes < 1000);
      pick = $urandom_range(0, 9);
      if (pick == 9) begin
        // noise: loose words, a few of them starting an image
        repeat ($urandom_range(1, 4)) begin
          send_word(8'($urandom()),
                    ($urandom_range(0, 1) == 0) ? $urandom() : 32'($urandom_range(0, 9)),
                    $urandom_range(0, 3) == 0, CHECK_MODEL, V_OK);
        end
      end else begin
        if (pick < 4) begin
          make_png();
        end else if (pick < 8) begin
          make_jpeg();
        end else begin
          img = {};
          repeat ($urandom_range(1, 6)) img.push_back(8'($urandom()));
        end
        n = img.size();
        case ($urandom_range(0, 19))
          13, 14: total = 32'(n + $urandom_range(1, 3));
          15, 16: total = 32'(n - $urandom_range(1, n));
          17: total = $urandom();
          18: total = 32'hffff_ffff;
          default: total = 32'(n);
        endcase
        if ($urandom_range(0, 7) == 0) begin
          cut = $urandom_range(0, n - 1);
          img[cut] = img[cut] ^ 8'(1 << $urandom_range(0, 7));
        end
        if ($urandom_range(0, 9) == 0) begin
          cut = $urandom_range(1, n);
          while (img.size() > cut) void'(img.pop_back());
        end
        foreach (img[i]) begin
          send_word(img[i], (i == 0) ? total : $urandom(), i == 0, CHECK_MODEL, V_OK);
        end
      end
    end
    calm = 1'b0;
    in_valid <= 1'b0;

    // Drain the remaining verdicts, then let the pipeline settle
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (verdict_q.size() != 0) begin
      report_mismatch($sformatf("%0d verdicts never arrived", verdict_q.size()));
    end
    if (mismatches == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

>>> filelist.f
src/pjca_pkg.sv
src/pjca_walker.sv
src/png_jpeg_container_admission.sv
src/pjca_checker.sv
test/testbench.sv
